@@ rtl/queued_melody_tone_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the melody tone sequencer
// Shared same-cycle and next-cycle implication checks on i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef QUEUED_MELODY_TONE_SEQUENCER_MACROS_SVH
`define QUEUED_MELODY_TONE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QMTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QMTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

@@ rtl/qmts_pkg.sv @@
// ----------------------------------------------------------------------------
// Melody tone sequencer package
// Request and status codes, the melody ROM and the control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package qmts_pkg;

    localparam int NOTE_TOTAL = 24;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_PLAY       = 3'd1,
        ACT_LOOP_START = 3'd2,
        ACT_LOOP_STOP  = 3'd3,
        ACT_SILENCE    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_IGNORED  = 2'd2,
        ST_TICK     = 2'd3
    } t_status;

    // Requests to the event FIFO; applied in the order clear, pop, push.
    typedef struct packed {
        logic       clear;
        logic       pop;
        logic       push;
        logic [2:0] push_event;
    } t_fifo_ctl;

    // What the note player reports for the item in flight.
    typedef struct packed {
        logic        busy;
        logic        ended;
        logic [11:0] tone_hz;
        logic [2:0]  cur_event;
    } t_play_sts;

    function automatic logic [4:0] mel_first(input logic [2:0] ev);
        logic [4:0] r;
        case (ev)
            3'd0:    r = 5'd0;
            3'd1:    r = 5'd3;
            3'd2:    r = 5'd6;
            3'd3:    r = 5'd9;
            3'd4:    r = 5'd13;
            3'd5:    r = 5'd15;
            3'd6:    r = 5'd18;
            default: r = 5'd23;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mel_len(input logic [2:0] ev);
        logic [2:0] r;
        case (ev)
            3'd3:    r = 3'd4;
            3'd4:    r = 3'd2;
            3'd6:    r = 3'd5;
            3'd7:    r = 3'd1;
            default: r = 3'd3;
        endcase
        return r;
    endfunction

    // Absolute ROM slot of a note, clamped to the last entry.
    function automatic logic [4:0] note_slot(input logic [2:0] ev, input logic [2:0] idx);
        logic [5:0] sum;
        sum = {1'b0, mel_first(ev)} + {3'b000, idx};
        return (sum < 6'(NOTE_TOTAL)) ? sum[4:0] : 5'(NOTE_TOTAL - 1);
    endfunction

    function automatic logic [11:0] note_hz(input logic [4:0] slot);
        logic [11:0] r;
        case (slot)
            5'd0, 5'd5:                 r = 12'd1568;
            5'd1, 5'd4:                 r = 12'd2093;
            5'd2, 5'd3:                 r = 12'd2637;
            5'd6, 5'd7, 5'd8:           r = 12'd2900;
            5'd9, 5'd10, 5'd11, 5'd12:  r = 12'd3300;
            5'd13, 5'd14, 5'd18, 5'd20: r = 12'd1200;
            5'd15:                      r = 12'd1760;
            5'd16:                      r = 12'd2200;
            5'd17:                      r = 12'd2640;
            5'd19, 5'd21:               r = 12'd1600;
            5'd22:                      r = 12'd2400;
            default:                    r = 12'd900;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] note_on(input logic [4:0] slot);
        logic [10:0] r;
        case (slot)
            5'd0, 5'd1, 5'd15, 5'd16:          r = 11'd70;
            5'd2, 5'd17:                       r = 11'd150;
            5'd3, 5'd4:                        r = 11'd80;
            5'd5, 5'd23:                       r = 11'd180;
            5'd6, 5'd7, 5'd8:                  r = 11'd130;
            5'd9, 5'd10, 5'd11:                r = 11'd160;
            5'd12:                             r = 11'd320;
            5'd13, 5'd14, 5'd18, 5'd19,
            5'd20, 5'd21:                      r = 11'd100;
            5'd22:                             r = 11'd220;
            default:                           r = 11'd180;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] note_off(input logic [4:0] slot);
        logic [10:0] r;
        case (slot)
            5'd0, 5'd1, 5'd3, 5'd4:       r = 11'd45;
            5'd6, 5'd7:                   r = 11'd90;
            5'd9, 5'd10, 5'd11:           r = 11'd70;
            5'd13:                        r = 11'd60;
            5'd14:                        r = 11'd2000;
            5'd15, 5'd16:                 r = 11'd40;
            5'd18, 5'd19, 5'd20, 5'd21:   r = 11'd55;
            default:                      r = 11'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/qmts_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one request or tick item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qmts_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] event_req;

    modport source (output valid, output action, output event_req, input ready);
    modport sink   (input valid, input action, input event_req, output ready);
endinterface

`default_nettype wire

@@ rtl/qmts_res_if.sv @@
// ----------------------------------------------------------------------------
// Result channel interface
// Carries one result item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qmts_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] tone_hz;
    logic        busy_res;
    logic [1:0]  status;
    logic [2:0]  queue_level;

    modport source (output valid, output tone_hz, output busy_res, output status,
                    output queue_level, input ready);
    modport sink   (input valid, input tone_hz, input busy_res, input status,
                    input queue_level, output ready);
endinterface

`default_nettype wire

@@ rtl/qmts_event_fifo.sv @@
// ----------------------------------------------------------------------------
// Event FIFO
// Circular queue of melody events with clear, pop and push in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "queued_melody_tone_sequencer_macros.svh"

module qmts_event_fifo #(
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire qmts_pkg::t_fifo_ctl i_ctl,
    output logic [CW-1:0]            o_count,
    output logic [CW-1:0]            o_next_count,
    output logic [2:0]               o_head_event
);

    logic [2:0]    r_mem [DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    logic [AW-1:0] head_b, head_p, slot;
    logic [CW-1:0] cnt_b, cnt_p;
    logic [AW:0]   slot_sum;
    logic          push_ok;
    logic          do_push;

    always_comb begin
        head_b = i_ctl.clear ? '0 : r_head;
        cnt_b  = i_ctl.clear ? '0 : r_count;
        if (i_ctl.pop) begin
            head_p = (head_b == AW'(DEPTH - 1)) ? '0 : head_b + AW'(1);
            cnt_p  = cnt_b - CW'(1);
        end else begin
            head_p = head_b;
            cnt_p  = cnt_b;
        end
        push_ok   = (cnt_p < CW'(DEPTH));
        do_push   = i_ctl.push && push_ok;
        // Sum stays below twice the depth, so one subtract wraps it.
        slot_sum  = {1'b0, head_p} + (AW + 1)'(cnt_p);
        slot      = (slot_sum >= (AW + 1)'(DEPTH)) ? AW'(slot_sum - (AW + 1)'(DEPTH))
                                                   : slot_sum[AW-1:0];
        n_head    = head_p;
        n_count   = cnt_p + CW'(do_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[slot] <= i_ctl.push_event;
        end
    end

    assign o_count      = r_count;
    assign o_next_count = n_count;
    assign o_head_event = r_mem[r_head];

    `QMTS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `QMTS_ASSERT_IMP(a_pop_nonempty, i_ctl.pop, r_count != '0)
    `QMTS_ASSERT_NXT(a_clear_level, i_ctl.clear && !i_ctl.pop, r_count <= CW'(1))

endmodule

`default_nettype wire

@@ rtl/qmts_note_player.sv @@
// ----------------------------------------------------------------------------
// Note player
// Holds the melody in progress and steps its notes and gaps on each tick.
// ----------------------------------------------------------------------------
`default_nettype none

module qmts_note_player (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_tick,
    input  wire                      i_start,
    input  wire [2:0]                i_start_event,
    output logic                     o_playing,
    output qmts_pkg::t_play_sts      o_sts
);

    logic        r_playing, n_playing;
    logic [2:0]  r_cur, n_cur;
    logic [2:0]  r_idx, n_idx;
    logic        r_gap, n_gap;
    logic [10:0] r_ms, n_ms;

    logic        play;
    logic [2:0]  cur, idx, idx_nx;
    logic        gap;
    logic [10:0] ms;
    logic [4:0]  slot_cur;

    always_comb begin
        // A popped event starts at its first note in the same tick.
        play     = i_start || r_playing;
        cur      = i_start ? i_start_event : r_cur;
        idx      = i_start ? 3'd0 : r_idx;
        gap      = i_start ? 1'b0 : r_gap;
        slot_cur = qmts_pkg::note_slot(cur, idx);
        ms       = i_start ? qmts_pkg::note_on(slot_cur) : r_ms;
        idx_nx   = idx + 3'd1;

        n_playing     = r_playing;
        n_cur         = r_cur;
        n_idx         = r_idx;
        n_gap         = r_gap;
        n_ms          = r_ms;
        o_sts.tone_hz = 12'd0;
        o_sts.ended   = 1'b0;

        if (i_tick && play) begin
            o_sts.tone_hz = gap ? 12'd0 : qmts_pkg::note_hz(slot_cur);
            n_playing     = 1'b1;
            n_cur         = cur;
            n_idx         = idx;
            n_gap         = gap;
            n_ms          = ms;
            if (ms > 11'd1) begin
                n_ms = ms - 11'd1;
            end else if (!gap && qmts_pkg::note_off(slot_cur) != 11'd0) begin
                n_gap = 1'b1;
                n_ms  = qmts_pkg::note_off(slot_cur);
            end else begin
                n_gap = 1'b0;
                if (idx_nx >= qmts_pkg::mel_len(cur)) begin
                    n_playing   = 1'b0;
                    n_idx       = 3'd0;
                    n_ms        = 11'd0;
                    o_sts.ended = 1'b1;
                end else begin
                    n_idx = idx_nx;
                    n_ms  = qmts_pkg::note_on(qmts_pkg::note_slot(cur, idx_nx));
                end
            end
        end

        o_sts.busy      = play;
        o_sts.cur_event = cur;
    end

    assign o_playing = r_playing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_cur     <= 3'd0;
            r_idx     <= 3'd0;
            r_gap     <= 1'b0;
            r_ms      <= 11'd0;
        end else if (i_en) begin
            r_playing <= n_playing;
            r_cur     <= n_cur;
            r_idx     <= n_idx;
            r_gap     <= n_gap;
            r_ms      <= n_ms;
        end
    end

endmodule

`default_nettype wire

@@ rtl/queued_melody_tone_sequencer.sv @@
// ----------------------------------------------------------------------------
// Queued melody tone sequencer
// Buzzer melody sequencer with an event FIFO, loop control and a note ROM.
// ----------------------------------------------------------------------------
// Usage:
// i_req carries one item per handshake: a one-millisecond tick or a request
// (play, start loop, stop loop, silence) with a melody number. Every item
// gives exactly one result item on o_res, in order.
// For a tick, o_res carries the buzzer frequency for that millisecond, the
// busy flag and status tick; for a request it carries the request status.
// queue_level is the FIFO fill after the item.
// An accepted item is held in the input register while the sequencer and
// FIFO update on its way into the result register, which drives o_res.
// One item is accepted per cycle while o_res drains.
// When o_res.ready is low the result register holds, the input register
// fills, and i_req.ready drops until the result is taken.
// Reset clears the FIFO, the loop and the player; the looped melody number
// resets to 4. The first item can be accepted right after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "queued_melody_tone_sequencer_macros.svh"

module queued_melody_tone_sequencer #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    qmts_req_if.sink   i_req,
    qmts_res_if.source o_res
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic        r_in_valid, n_in_valid;
    logic [2:0]  r_action;
    logic [2:0]  r_event;
    logic        r_out_valid, n_out_valid;
    logic [11:0] r_tone;
    logic        r_busy;
    logic [1:0]  r_status;
    logic [2:0]  r_level;

    logic        r_loop_armed, n_loop_armed;
    logic [2:0]  r_looped, n_looped;

    logic                advance;
    logic                take_in;
    logic                is_tick;
    logic                start;
    logic                player_playing;
    qmts_pkg::t_fifo_ctl fifo_ctl;
    qmts_pkg::t_play_sts play_sts;
    qmts_pkg::t_status   status;
    logic [CW-1:0]       fifo_count;
    logic [CW-1:0]       fifo_next_count;
    logic [2:0]          fifo_head_event;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign take_in     = i_req.valid && i_req.ready;
    assign is_tick     = (r_action == qmts_pkg::ACT_TICK);
    assign start       = advance && is_tick && !player_playing && fifo_count != '0;

    qmts_event_fifo #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (fifo_ctl),
        .o_count      (fifo_count),
        .o_next_count (fifo_next_count),
        .o_head_event (fifo_head_event)
    );

    qmts_note_player u_player (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_tick        (is_tick),
        .i_start       (start),
        .i_start_event (fifo_head_event),
        .o_playing     (player_playing),
        .o_sts         (play_sts)
    );

    always_comb begin
        fifo_ctl.clear      = 1'b0;
        fifo_ctl.pop        = 1'b0;
        fifo_ctl.push       = 1'b0;
        fifo_ctl.push_event = r_event;
        n_loop_armed        = r_loop_armed;
        n_looped            = r_looped;
        status              = qmts_pkg::ST_IGNORED;

        case (r_action)
            qmts_pkg::ACT_TICK: begin
                status              = qmts_pkg::ST_TICK;
                fifo_ctl.pop        = start;
                // A looped melody queues itself again when it ends.
                fifo_ctl.push       = play_sts.ended && r_loop_armed
                                      && (play_sts.cur_event == r_looped);
                fifo_ctl.push_event = play_sts.cur_event;
            end
            qmts_pkg::ACT_PLAY: begin
                fifo_ctl.push = 1'b1;
                status        = (fifo_count < CW'(FIFO_DEPTH)) ? qmts_pkg::ST_ACCEPTED
                                                               : qmts_pkg::ST_DROPPED;
            end
            qmts_pkg::ACT_LOOP_START: begin
                n_looped       = r_event;
                n_loop_armed   = 1'b1;
                fifo_ctl.clear = 1'b1;
                fifo_ctl.push  = 1'b1;
                status         = qmts_pkg::ST_ACCEPTED;
            end
            qmts_pkg::ACT_LOOP_STOP: begin
                if (r_loop_armed && r_looped == r_event) begin
                    n_loop_armed   = 1'b0;
                    fifo_ctl.clear = 1'b1;
                    status         = qmts_pkg::ST_ACCEPTED;
                end
            end
            qmts_pkg::ACT_SILENCE: begin
                n_loop_armed   = 1'b0;
                fifo_ctl.clear = 1'b1;
                status         = qmts_pkg::ST_ACCEPTED;
            end
            default: begin
                status = qmts_pkg::ST_IGNORED;
            end
        endcase

        if (!advance) begin
            fifo_ctl.clear = 1'b0;
            fifo_ctl.pop   = 1'b0;
            fifo_ctl.push  = 1'b0;
            n_loop_armed   = r_loop_armed;
            n_looped       = r_looped;
        end

        n_in_valid = take_in ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_loop_armed <= 1'b0;
            r_looped     <= 3'd4;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_loop_armed <= n_loop_armed;
            r_looped     <= n_looped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_action <= i_req.action;
            r_event  <= i_req.event_req;
        end
        if (advance) begin
            r_tone   <= play_sts.tone_hz;
            r_busy   <= play_sts.busy;
            r_status <= status;
            r_level  <= 3'(fifo_next_count);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.tone_hz     = r_tone;
    assign o_res.busy_res    = r_busy;
    assign o_res.status      = r_status;
    assign o_res.queue_level = r_level;

    `QMTS_ASSERT_NXT(a_advance_shows, advance, r_out_valid)
    `QMTS_ASSERT_IMP(a_start_on_tick, start, is_tick && fifo_ctl.pop)
    `QMTS_ASSERT_IMP(a_ready_empty, !r_in_valid, i_req.ready)

endmodule

`default_nettype wire
